// ===== rtl/crq_pkg.sv =====
`default_nettype none

package crq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W = 40;

   typedef enum logic [1:0] {
      ACT_REPORT = 2'd0,
      ACT_POLL   = 2'd1,
      ACT_GRANT  = 2'd2,
      ACT_DONE   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_QUEUED      = 4'd0,
      ST_DUPLICATE   = 4'd1,
      ST_FULL        = 4'd2,
      ST_IDLE        = 4'd3,
      ST_REQUESTED   = 4'd4,
      ST_REQ_FAILED  = 4'd5,
      ST_POPPED      = 4'd6,
      ST_EMPTY_GRANT = 4'd7,
      ST_DONE        = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_POP,
      SEQ_RESULT
   } seq_state_type;

   typedef struct packed {
      logic [7:0]  endpoint;
      logic [15:0] cluster;
      logic [15:0] attribute;
   } key_type;

   typedef struct packed {
      action_type action;
      key_type    key;
      logic       buffer_ok;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       out_valid;
      key_type    key;
      logic [3:0] queue_count;
   } result_type;

   // ring pointer step, wraps at the queue depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   function automatic logic [3:0] count_low4(input logic [CNT_W-1:0] c);
      logic [CNT_W+3:0] w;
      w = {4'b0000, c};
      return w[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crq_if.sv =====
`default_nettype none

interface crq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  endpoint;
   logic [15:0] cluster;
   logic [15:0] attribute;
   logic        buffer_ok;

   modport source (output valid, output action, output endpoint, output cluster,
                   output attribute, output buffer_ok, input ready);
   modport sink (input valid, input action, input endpoint, input cluster,
                 input attribute, input buffer_ok, output ready);
endinterface

interface crq_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic        out_valid;
   logic [7:0]  out_endpoint;
   logic [15:0] out_cluster;
   logic [15:0] out_attribute;
   logic [3:0]  queue_count;

   modport source (output valid, output status, output out_valid, output out_endpoint,
                   output out_cluster, output out_attribute, output queue_count,
                   input ready);
   modport sink (input valid, input status, input out_valid, input out_endpoint,
                 input out_cluster, input out_attribute, input queue_count,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/crq_ram.sv =====
`default_nettype none

module crq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/crq_seq.sv =====
`default_nettype none

module crq_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   output      logic                item_ready,
   input  wire crq_pkg::item_type   item,
   output      logic                res_valid,
   input  wire logic                res_ready,
   output      crq_pkg::result_type res
);
   import crq_pkg::*;

   seq_state_type    state_ff, state_in;
   item_type         item_ff, item_in;
   result_type       res_ff, res_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] addr_ff, addr_in;
   logic [PTR_W-1:0] scan_ff, scan_in;
   logic             in_flight_ff, in_flight_in;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [KEY_W-1:0] ram_wdata;
   logic [PTR_W-1:0] ram_raddr;
   logic [KEY_W-1:0] ram_rdata;
   logic             scan_last;

   crq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         in_flight_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         in_flight_ff <= in_flight_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      addr_ff <= addr_in;
      scan_ff <= scan_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      addr_in      = addr_ff;
      scan_in      = scan_ff;
      in_flight_in = in_flight_ff;
      item_ready   = 1'b0;
      res_valid    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = item_ff.key;
      ram_raddr    = addr_ff;

      case (state_ff)
         SEQ_IDLE: begin
            item_ready = 1'b1;
            // head read starts now so the scan or pop sees it next cycle
            ram_raddr  = head_ff;
            if (item_valid) begin
               item_in             = item;
               res_in              = '0;
               res_in.queue_count  = count_low4(count_ff);
               addr_in             = head_ff;
               scan_in             = '0;
               state_in            = SEQ_RESULT;
               case (item.action)
                  ACT_REPORT: begin
                     if (count_ff == '0) begin
                        ram_we             = 1'b1;
                        ram_wdata          = item.key;
                        tail_in            = ptr_inc(tail_ff);
                        count_in           = count_ff + CNT_W'(1);
                        res_in.status      = ST_QUEUED;
                        res_in.queue_count = count_low4(count_ff + CNT_W'(1));
                     end else begin
                        state_in = SEQ_SCAN;
                     end
                  end
                  ACT_POLL: begin
                     if (count_ff != '0 && !in_flight_ff) begin
                        if (item.buffer_ok) begin
                           in_flight_in  = 1'b1;
                           res_in.status = ST_REQUESTED;
                        end else begin
                           res_in.status = ST_REQ_FAILED;
                        end
                     end else begin
                        res_in.status = ST_IDLE;
                     end
                  end
                  ACT_GRANT: begin
                     if (count_ff == '0) begin
                        in_flight_in  = 1'b0;
                        res_in.status = ST_EMPTY_GRANT;
                     end else begin
                        state_in = SEQ_POP;
                     end
                  end
                  default: begin
                     in_flight_in  = 1'b0;
                     res_in.status = ST_DONE;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            // one stored key compared per cycle, next one read in parallel
            if (key_type'(ram_rdata) == item_ff.key) begin
               res_in.status = ST_DUPLICATE;
               state_in      = SEQ_RESULT;
            end else if (scan_last) begin
               if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                  ram_we             = 1'b1;
                  tail_in            = ptr_inc(tail_ff);
                  count_in           = count_ff + CNT_W'(1);
                  res_in.status      = ST_QUEUED;
                  res_in.queue_count = count_low4(count_ff + CNT_W'(1));
               end else begin
                  res_in.status = ST_FULL;
               end
               state_in = SEQ_RESULT;
            end else begin
               scan_in   = scan_ff + PTR_W'(1);
               addr_in   = ptr_inc(addr_ff);
               ram_raddr = ptr_inc(addr_ff);
            end
         end
         SEQ_POP: begin
            res_in.out_valid   = 1'b1;
            res_in.key         = key_type'(ram_rdata);
            res_in.status      = ST_POPPED;
            res_in.queue_count = count_low4(count_ff - CNT_W'(1));
            head_in            = ptr_inc(head_ff);
            count_in           = count_ff - CNT_W'(1);
            state_in           = SEQ_RESULT;
         end
         SEQ_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> count_ff < CNT_W'(QUEUE_DEPTH))
      else $error("append with a full queue");

   a_write_bumps_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance the count");

   a_head_moves_on_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff != SEQ_POP |=> head_ff == $past(head_ff))
      else $error("head moved outside a pop");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      item_valid && item_ready |=> !item_ready)
      else $error("new transfer accepted while an item is in work");

   a_entry_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.out_valid |-> res.status == ST_POPPED)
      else $error("entry presented without a pop");

endmodule

`default_nettype wire

// ===== rtl/coalescing_report_queue.sv =====
`default_nettype none

// path, transfer in to result: poll, done, empty grant and a report into an empty queue
// set the result straight from idle; a pop first reads the head entry in the pop state,
// other reports first compare the stored entries one by one in the scan state
// throughput: one item at a time, the next transfer in is taken once the result has
// moved on to the output register and the sequencer is idle again; the duplicate scan
// reads one entry per cycle through one shared comparator
// reset: synchronous, active high; clears count, pointers, in-flight flag and output
// valid, entry RAM contents are not cleared

module coalescing_report_queue (
   input wire logic   clock,
   input wire logic   reset,
   crq_req_if.sink    req_ch,
   crq_rsp_if.source  rsp_ch
);
   import crq_pkg::*;

   item_type   item;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign item.action    = action_type'(req_ch.action);
   assign item.key       = '{endpoint: req_ch.endpoint, cluster: req_ch.cluster,
                             attribute: req_ch.attribute};
   assign item.buffer_ok = req_ch.buffer_ok;

   crq_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_ch.valid),
      .item_ready (req_ch.ready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // output register frees as soon as the held result transfers
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.out_valid     = rsp_ff.out_valid;
   assign rsp_ch.out_endpoint  = rsp_ff.key.endpoint;
   assign rsp_ch.out_cluster   = rsp_ff.key.cluster;
   assign rsp_ch.out_attribute = rsp_ff.key.attribute;
   assign rsp_ch.queue_count   = rsp_ff.queue_count;

endmodule

`default_nettype wire

// ===== tb/crq_report_checker.sv =====
`timescale 1ns / 1ps

module crq_report_checker (
   input  wire logic clock,
   input  wire logic reset,
   crq_req_if        req_mon,
   crq_rsp_if        rsp_mon,
   output int        mismatches,
   output int        outstanding,
   output int        results_checked,
   output int        pops_seen,
   output int        full_drops
);
   import crq_pkg::*;

   // shadow copy of the queue
   key_type    shadow_slots [QUEUE_DEPTH];
   int         shadow_count = 0;
   bit         shadow_in_flight = 1'b0;

   result_type awaited_results [$];
   int         mismatch_total = 0;
   int         checked_total = 0;
   int         pop_total = 0;
   int         full_total = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
      mismatch_total++;
   endtask

   function automatic result_type predict_report_queue(input action_type act,
                                                       input key_type key,
                                                       input logic ok);
      result_type res;
      bit         hit;
      int         i;
      res = '0;
      res.status = ST_IDLE;
      hit = 1'b0;
      case (act)
         ACT_REPORT: begin
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_slots[i] == key) begin
                  hit = 1'b1;
               end
            end
            if (hit) begin
               res.status = ST_DUPLICATE;
            end else if (shadow_count < QUEUE_DEPTH) begin
               shadow_slots[shadow_count] = key;
               shadow_count++;
               res.status = ST_QUEUED;
            end else begin
               res.status = ST_FULL;
            end
         end
         ACT_POLL: begin
            if (shadow_count > 0 && !shadow_in_flight) begin
               if (ok) begin
                  shadow_in_flight = 1'b1;
                  res.status = ST_REQUESTED;
               end else begin
                  res.status = ST_REQ_FAILED;
               end
            end
         end
         ACT_GRANT: begin
            if (shadow_count == 0) begin
               shadow_in_flight = 1'b0;
               res.status = ST_EMPTY_GRANT;
            end else begin
               res.out_valid = 1'b1;
               res.key = shadow_slots[0];
               for (i = 1; i < shadow_count; i++) begin
                  shadow_slots[i-1] = shadow_slots[i];
               end
               shadow_count--;
               res.status = ST_POPPED;
            end
         end
         default: begin
            shadow_in_flight = 1'b0;
            res.status = ST_DONE;
         end
      endcase
      res.queue_count = 4'(shadow_count);
      return res;
   endfunction

   always @(posedge clock) begin
      key_type    req_key;
      result_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_in_flight = 1'b0;
         awaited_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            req_key.endpoint = req_mon.endpoint;
            req_key.cluster = req_mon.cluster;
            req_key.attribute = req_mon.attribute;
            want = predict_report_queue(action_type'(req_mon.action), req_key,
                                        req_mon.buffer_ok);
            awaited_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result status", int'(rsp_mon.status), 0);
            end else begin
               want = awaited_results.pop_front();
               checked_total++;
               if (want.status == ST_POPPED) pop_total++;
               if (want.status == ST_FULL) full_total++;
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", int'(rsp_mon.status), int'(want.status));
               if (rsp_mon.out_valid !== want.out_valid)
                  report_mismatch("out_valid", int'(rsp_mon.out_valid), int'(want.out_valid));
               if (rsp_mon.out_endpoint !== want.key.endpoint)
                  report_mismatch("out_endpoint", int'(rsp_mon.out_endpoint),
                                  int'(want.key.endpoint));
               if (rsp_mon.out_cluster !== want.key.cluster)
                  report_mismatch("out_cluster", int'(rsp_mon.out_cluster),
                                  int'(want.key.cluster));
               if (rsp_mon.out_attribute !== want.key.attribute)
                  report_mismatch("out_attribute", int'(rsp_mon.out_attribute),
                                  int'(want.key.attribute));
               if (rsp_mon.queue_count !== want.queue_count)
                  report_mismatch("queue_count", int'(rsp_mon.queue_count),
                                  int'(want.queue_count));
            end
         end
      end
      mismatches <= mismatch_total;
      outstanding <= awaited_results.size();
      results_checked <= checked_total;
      pops_seen <= pop_total;
      full_drops <= full_total;
   end

endmodule

// ===== tb/coalescing_report_queue_test.sv =====
`timescale 1ns / 1ps

module coalescing_report_queue_test;
   import crq_pkg::*;

   localparam int RANDOM_ITEMS   = 1700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = QUEUE_DEPTH + 12;

   logic clock;
   logic reset;

   crq_req_if req_ch ();
   crq_rsp_if rsp_ch ();

   int  mismatches;
   int  outstanding;
   int  results_checked;
   int  pops_seen;
   int  full_drops;
   int  items_sent;
   int  idle_cycles;
   int  stall_left;
   bit  quiet;

   coalescing_report_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   crq_report_checker report_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .pops_seen       (pops_seen),
      .full_drops      (full_drops)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // small key pool so duplicates are common, full-range keys for bit coverage
   function automatic key_type pick_key();
      key_type k;
      if ($urandom_range(0, 2) == 0) begin
         k.endpoint = 8'($urandom);
         k.cluster = 16'($urandom);
         k.attribute = 16'($urandom);
      end else begin
         k.endpoint = 8'($urandom_range(0, 3));
         k.cluster = ($urandom_range(0, 1) == 0) ? 16'h0006 : 16'h0402;
         k.attribute = 16'($urandom_range(0, 3));
      end
      return k;
   endfunction

   task automatic send_item(input action_type act, input key_type key, input logic ok);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.endpoint <= key.endpoint;
      req_ch.cluster <= key.cluster;
      req_ch.attribute <= key.attribute;
      req_ch.buffer_ok <= ok;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic run_directed();
      int i;
      send_item(ACT_GRANT, pick_key(), 1'b1);
      send_item(ACT_POLL, pick_key(), 1'b1);
      send_item(ACT_DONE, pick_key(), 1'b0);
      send_item(ACT_REPORT, key_type'{8'h00, 16'h0000, 16'h0000}, 1'b0);
      send_item(ACT_REPORT, key_type'{8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1);
      send_item(ACT_REPORT, key_type'{8'h00, 16'h0000, 16'h0000}, 1'b1);
      // differs from a queued key in the attribute only
      send_item(ACT_REPORT, key_type'{8'h00, 16'h0000, 16'h0001}, 1'b0);
      send_item(ACT_POLL, pick_key(), 1'b0);
      send_item(ACT_POLL, pick_key(), 1'b1);
      send_item(ACT_POLL, pick_key(), 1'b1);
      send_item(ACT_GRANT, pick_key(), 1'b0);
      send_item(ACT_DONE, pick_key(), 1'b1);
      // pop with nothing in flight
      send_item(ACT_GRANT, pick_key(), 1'b0);
      for (i = 0; i < QUEUE_DEPTH - 1; i++) begin
         send_item(ACT_REPORT, key_type'{8'(i + 16), 16'h1234, 16'(16'h8000 + i)}, 1'b1);
      end
      send_item(ACT_REPORT, key_type'{8'h7F, 16'h5555, 16'hAAAA}, 1'b0);
      // duplicate wins over full
      send_item(ACT_REPORT, key_type'{8'h00, 16'h0000, 16'h0001}, 1'b1);
      send_item(ACT_POLL, pick_key(), 1'b1);
      send_item(ACT_GRANT, pick_key(), 1'b1);
      send_item(ACT_GRANT, pick_key(), 1'b0);
   endtask

   task automatic run_random();
      int target;
      int burst;
      int n;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         quiet = ((items_sent % 200) < 30);
         if ($urandom_range(0, 9) < 7) begin
            // report burst, then poll, grant and usually done
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : $urandom_range(0, 4);
            for (n = 0; n < burst; n++) begin
               send_item(ACT_REPORT, pick_key(), 1'($urandom));
            end
            send_item(ACT_POLL, pick_key(), ($urandom_range(0, 5) != 0));
            send_item(ACT_GRANT, pick_key(), 1'($urandom));
            if ($urandom_range(0, 3) != 0) begin
               send_item(ACT_DONE, pick_key(), 1'($urandom));
            end
         end else begin
            burst = $urandom_range(1, 6);
            for (n = 0; n < burst; n++) begin
               send_item(action_type'($urandom_range(0, 3)), pick_key(), 1'($urandom));
            end
         end
      end
   endtask

   initial begin
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      items_sent = 0;
      quiet = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_REPORT;
      req_ch.endpoint <= '0;
      req_ch.cluster <= '0;
      req_ch.attribute <= '0;
      req_ch.buffer_ok <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_ch.valid <= 1'b0;
      // let the checker count the last transfer before waiting on it
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d items, checked %0d results", items_sent, results_checked);
      $display("covered %0d pops and %0d full drops, %0d mismatches",
               pops_seen, full_drops, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
